/* sv/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg
// Shared widths, step constants, calendar tables and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

    // field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 23;
    localparam int DIFF_W   = 23;

    // internal widths: biased year counter, day number, signed running count
    localparam int YR_W = 17;
    localparam int DN_W = 23;
    localparam int N_W  = 25;

    localparam int unsigned MAX_YEAR_DEF = 9999;
    localparam int unsigned YEAR_BIAS    = 400;

    // day counts of the step sizes
    localparam logic [DN_W-1:0] ERA_DAYS  = DN_W'(146097);
    localparam logic [DN_W-1:0] CENT_DAYS = DN_W'(36524);
    localparam logic [DN_W-1:0] QUAD_DAYS = DN_W'(1461);
    localparam logic [DN_W-1:0] YEAR_DAYS = DN_W'(365);

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_BAD_INPUT = 2'd1,
        ERR_RANGE     = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        STEP_ERA   = 3'd0,
        STEP_CENT  = 3'd1,
        STEP_QUAD  = 3'd2,
        STEP_YEAR  = 3'd3,
        STEP_MONTH = 3'd4
    } step_t;

    // controller to datapath
    typedef struct packed {
        logic  load;       // capture the input word
        logic  init_fwd;   // set up date to day number for the selected date
        logic  sel_b;      // selects date b
        logic  fwd_step;   // one step of date to day number
        logic  chk_feb;    // settle the february 29 check
        logic  save;       // store the finished day number
        logic  init_rev;   // set up day number to date
        logic  rev_step;   // one step of day number to date
        step_t kind;       // size of the step
        logic  clr_cnt;    // clear the bounded step counter
        logic  finish;     // load the result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic yr_ge400;
        logic yr_ge100;
        logic yr_ge4;
        logic yr_nz;
        logic n_ge_era;
        logic n_ge_cent;
        logic n_ge_quad;
        logic n_ge_year;
        logic n_ge_month;
    } sts_t;

    // length of a month in a common year, zero for a code that is no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days from march 1 to the first of the month
    function automatic logic [8:0] march_cum(input logic [MONTH_W-1:0] m);
        logic [8:0] days;
        unique case (m)
            4'd3:    days = 9'd0;
            4'd4:    days = 9'd31;
            4'd5:    days = 9'd61;
            4'd6:    days = 9'd92;
            4'd7:    days = 9'd122;
            4'd8:    days = 9'd153;
            4'd9:    days = 9'd184;
            4'd10:   days = 9'd214;
            4'd11:   days = 9'd245;
            4'd12:   days = 9'd275;
            4'd1:    days = 9'd306;
            4'd2:    days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // month length by month index counted from march, february last
    function automatic logic [DAY_W-1:0] march_len(input logic [MONTH_W-1:0] mp);
        logic [DAY_W-1:0] len;
        unique case (mp)
            4'd1, 4'd3, 4'd6, 4'd8: len = 5'd30;
            4'd11:                  len = 5'd29;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

/* sv/gda_if.sv */
// ----------------------------------------------------------------------------
// gda_in_if / gda_out_if
// Valid/ready channels for the request word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gda_in_if import gda_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [YEAR_W-1:0]          year_a;
    logic [MONTH_W-1:0]         month_a;
    logic [DAY_W-1:0]           day_a;
    logic [YEAR_W-1:0]          year_b;
    logic [MONTH_W-1:0]         month_b;
    logic [DAY_W-1:0]           day_b;
    logic signed [OFFSET_W-1:0] day_offset;

    modport source (
        output valid, operation, year_a, month_a, day_a,
               year_b, month_b, day_b, day_offset,
        input  ready
    );

    modport sink (
        input  valid, operation, year_a, month_a, day_a,
               year_b, month_b, day_b, day_offset,
        output ready
    );
endinterface

interface gda_out_if import gda_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [YEAR_W-1:0]        year_out;
    logic [MONTH_W-1:0]       month_out;
    logic [DAY_W-1:0]         day_out;
    logic signed [DIFF_W-1:0] day_difference;
    logic                     a_before_b;
    logic                     dates_equal;
    logic [1:0]               error;

    modport source (
        output valid, year_out, month_out, day_out, day_difference,
               a_before_b, dates_equal, error,
        input  ready
    );

    modport sink (
        input  valid, year_out, month_out, day_out, day_difference,
               a_before_b, dates_equal, error,
        output ready
    );
endinterface

`default_nettype wire

/* sv/gda_datapath.sv */
// ----------------------------------------------------------------------------
// gda_datapath
// Input and result registers, the year counter and day count accumulators
// with their step adders, validity checks and the final result selection.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_datapath import gda_pkg::*; #(
    parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cmd_t                       cmd,
    output sts_t                            sts,
    input  wire logic                       operation,
    input  wire logic [YEAR_W-1:0]          year_a,
    input  wire logic [MONTH_W-1:0]         month_a,
    input  wire logic [DAY_W-1:0]           day_a,
    input  wire logic [YEAR_W-1:0]          year_b,
    input  wire logic [MONTH_W-1:0]         month_b,
    input  wire logic [DAY_W-1:0]           day_b,
    input  wire logic signed [OFFSET_W-1:0] day_offset,
    output logic [YEAR_W-1:0]               year_out,
    output logic [MONTH_W-1:0]              month_out,
    output logic [DAY_W-1:0]                day_out,
    output logic signed [DIFF_W-1:0]        day_difference,
    output logic                            a_before_b,
    output logic                            dates_equal,
    output logic [1:0]                      error
);

    localparam logic [YR_W-1:0] MAX_YEAR_W = YR_W'(MAX_YEAR);
    localparam logic [YR_W-1:0] BIAS_W     = YR_W'(YEAR_BIAS);

    // captured input word
    logic                       op_reg;
    logic [YEAR_W-1:0]          ya_reg, yb_reg;
    logic [MONTH_W-1:0]         ma_reg, mb_reg;
    logic [DAY_W-1:0]           da_reg, db_reg;
    logic signed [OFFSET_W-1:0] off_reg;

    // working registers
    logic [YR_W-1:0]       yr_reg;
    logic [DN_W-1:0]       acc_reg;
    logic [DN_W-1:0]       na_reg, nb_reg;
    logic signed [N_W-1:0] n_reg;
    logic [1:0]            cnt_reg;
    logic [MONTH_W-1:0]    mp_reg;
    logic                  bad_reg;
    logic                  feb29_reg;

    // result registers
    logic [YEAR_W-1:0]        year_out_reg;
    logic [MONTH_W-1:0]       month_out_reg;
    logic [DAY_W-1:0]         day_out_reg;
    logic signed [DIFF_W-1:0] diff_out_reg;
    logic                     before_reg;
    logic                     equal_reg;
    err_t                     err_reg;

    // selected date for the forward conversion
    logic [YEAR_W-1:0]  y_sel;
    logic [MONTH_W-1:0] m_sel;
    logic [DAY_W-1:0]   d_sel;
    logic               janfeb;
    logic [DAY_W-1:0]   dlen;
    logic [YR_W-1:0]    yr_init;
    logic [DN_W-1:0]    acc_init;
    logic               bad_now;
    logic               feb29_now;
    logic               leap_yoe;

    // step sizes
    logic [YR_W-1:0] step_yr;
    logic [DN_W-1:0] step_days;

    // result selection
    logic [MONTH_W-1:0]       mm_fin;
    logic [YR_W-1:0]          yfin;
    logic [YR_W-1:0]          yfin_unb;
    logic                     range_ok;
    logic [DN_W:0]            diff_full;
    logic [YEAR_W-1:0]        year_fin;
    logic [MONTH_W-1:0]       month_fin;
    logic [DAY_W-1:0]         day_fin;
    logic signed [DIFF_W-1:0] diff_fin;
    logic                     before_fin;
    logic                     equal_fin;
    err_t                     err_fin;

    // date under conversion and its checks
    always_comb
    begin
        y_sel     = cmd.sel_b ? yb_reg : ya_reg;
        m_sel     = cmd.sel_b ? mb_reg : ma_reg;
        d_sel     = cmd.sel_b ? db_reg : da_reg;
        janfeb    = (m_sel == 4'd1) || (m_sel == 4'd2);
        dlen      = (m_sel == 4'd2) ? 5'd29 : month_len(m_sel);
        yr_init   = YR_W'(y_sel) + BIAS_W - YR_W'(janfeb);
        acc_init  = DN_W'(march_cum(m_sel)) + DN_W'(d_sel) - DN_W'(1);
        bad_now   = (YR_W'(y_sel) > MAX_YEAR_W) || (dlen == 5'd0) ||
                    (d_sel == 5'd0) || (d_sel > dlen);
        feb29_now = (m_sel == 4'd2) && (d_sel == 5'd29);
    end

    // leap test of the february year once the year is reduced below one era
    assign leap_yoe = (yr_reg == YR_W'(399)) ||
                      ((yr_reg[1:0] == 2'b11) && (yr_reg != YR_W'(99)) &&
                       (yr_reg != YR_W'(199)) && (yr_reg != YR_W'(299)));

    // step sizes by kind
    always_comb
    begin
        case (cmd.kind)
            STEP_ERA:
            begin
                step_yr   = YR_W'(400);
                step_days = ERA_DAYS;
            end
            STEP_CENT:
            begin
                step_yr   = YR_W'(100);
                step_days = CENT_DAYS;
            end
            STEP_QUAD:
            begin
                step_yr   = YR_W'(4);
                step_days = QUAD_DAYS;
            end
            STEP_YEAR:
            begin
                step_yr   = YR_W'(1);
                step_days = YEAR_DAYS;
            end
            STEP_MONTH:
            begin
                step_yr   = '0;
                step_days = DN_W'(march_len(mp_reg));
            end
            default:
            begin
                step_yr   = '0;
                step_days = '0;
            end
        endcase
    end

    // status toward the controller
    always_comb
    begin
        sts.op         = op_reg;
        sts.yr_ge400   = yr_reg >= YR_W'(400);
        sts.yr_ge100   = yr_reg >= YR_W'(100);
        sts.yr_ge4     = yr_reg >= YR_W'(4);
        sts.yr_nz      = yr_reg != '0;
        sts.n_ge_era   = n_reg >= $signed({2'b00, ERA_DAYS});
        sts.n_ge_cent  = (n_reg >= $signed({2'b00, CENT_DAYS})) && (cnt_reg != 2'd3);
        sts.n_ge_quad  = n_reg >= $signed({2'b00, QUAD_DAYS});
        sts.n_ge_year  = (n_reg >= $signed({2'b00, YEAR_DAYS})) && (cnt_reg != 2'd3);
        sts.n_ge_month = (mp_reg < 4'd11) &&
                         (n_reg >= $signed({{(N_W-DAY_W){1'b0}}, march_len(mp_reg)}));
    end

    // final result word
    always_comb
    begin
        mm_fin    = (mp_reg < 4'd10) ? mp_reg + 4'd3 : mp_reg - 4'd9;
        yfin      = yr_reg + YR_W'((mm_fin == 4'd1) || (mm_fin == 4'd2));
        yfin_unb  = yfin - BIAS_W;
        range_ok  = !n_reg[N_W-1] && (yfin >= BIAS_W) && (yfin_unb <= MAX_YEAR_W);
        diff_full = {1'b0, na_reg} - {1'b0, nb_reg};

        year_fin   = '0;
        month_fin  = '0;
        day_fin    = '0;
        diff_fin   = '0;
        before_fin = 1'b0;
        equal_fin  = 1'b0;
        err_fin    = ERR_OK;

        if (bad_reg)
        begin
            err_fin = ERR_BAD_INPUT;
        end
        else if (op_reg)
        begin
            diff_fin   = $signed(diff_full[DIFF_W-1:0]);
            before_fin = na_reg < nb_reg;
            equal_fin  = na_reg == nb_reg;
        end
        else if (!range_ok)
        begin
            err_fin = ERR_RANGE;
        end
        else
        begin
            year_fin  = yfin_unb[YEAR_W-1:0];
            month_fin = mm_fin;
            day_fin   = n_reg[DAY_W-1:0] + 5'd1;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            ya_reg  <= year_a;
            ma_reg  <= month_a;
            da_reg  <= day_a;
            yb_reg  <= year_b;
            mb_reg  <= month_b;
            db_reg  <= day_b;
            off_reg <= day_offset;
            bad_reg <= 1'b0;
        end
        if (cmd.init_fwd)
        begin
            yr_reg    <= yr_init;
            acc_reg   <= acc_init;
            feb29_reg <= feb29_now;
            if (bad_now)
            begin
                bad_reg <= 1'b1;
            end
        end
        if (cmd.chk_feb && feb29_reg && !leap_yoe)
        begin
            bad_reg <= 1'b1;
        end
        if (cmd.fwd_step)
        begin
            yr_reg  <= yr_reg - step_yr;
            acc_reg <= acc_reg + step_days;
        end
        if (cmd.save)
        begin
            if (cmd.sel_b)
            begin
                nb_reg <= acc_reg;
            end
            else
            begin
                na_reg <= acc_reg;
            end
        end
        if (cmd.init_rev)
        begin
            n_reg  <= $signed({2'b00, na_reg}) +
                      $signed({{(N_W-OFFSET_W){off_reg[OFFSET_W-1]}}, off_reg});
            yr_reg <= '0;
        end
        if (cmd.rev_step)
        begin
            yr_reg <= yr_reg + step_yr;
            n_reg  <= n_reg - $signed({2'b00, step_days});
        end
        if (cmd.finish)
        begin
            year_out_reg  <= year_fin;
            month_out_reg <= month_fin;
            day_out_reg   <= day_fin;
            diff_out_reg  <= diff_fin;
            before_reg    <= before_fin;
            equal_reg     <= equal_fin;
            err_reg       <= err_fin;
        end
    end

    // bounded step counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            mp_reg  <= '0;
        end
        else if (cmd.init_rev)
        begin
            cnt_reg <= '0;
            mp_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.rev_step && ((cmd.kind == STEP_CENT) || (cmd.kind == STEP_YEAR)))
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (cmd.rev_step && (cmd.kind == STEP_MONTH))
            begin
                mp_reg <= mp_reg + 4'd1;
            end
        end
    end

    assign year_out       = year_out_reg;
    assign month_out      = month_out_reg;
    assign day_out        = day_out_reg;
    assign day_difference = diff_out_reg;
    assign a_before_b     = before_reg;
    assign dates_equal    = equal_reg;
    assign error          = err_reg;

    // month index never walks past february
    a_mp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mp_reg <= 4'd11)
        else $error("month index past february");

    // the february check sees a year already reduced below one era
    a_feb_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chk_feb |-> (yr_reg < YR_W'(400)))
        else $error("february check before era reduction finished");

    // a good shift result leaves a day offset inside one month
    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !op_reg && !bad_reg && !n_reg[N_W-1]) |->
        (n_reg < $signed(N_W'(31))))
        else $error("day remainder out of month");

endmodule

`default_nettype wire

/* sv/gda_ctrl.sv */
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer for the date conversions: date to day number for one or two
// dates, then day number back to a date for a shift, then the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_ctrl import gda_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_INIT    = 14'b00000000000010,
        S_ERA_F   = 14'b00000000000100,
        S_CENT_F  = 14'b00000000001000,
        S_QUAD_F  = 14'b00000000010000,
        S_YEAR_F  = 14'b00000000100000,
        S_SAVE    = 14'b00000001000000,
        S_INIT_R  = 14'b00000010000000,
        S_ERA_R   = 14'b00000100000000,
        S_CENT_R  = 14'b00001000000000,
        S_QUAD_R  = 14'b00010000000000,
        S_YEAR_R  = 14'b00100000000000,
        S_MONTH_R = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_b_reg, sel_b_next;
    logic   out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        sel_b_next = sel_b_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.kind   = STEP_ERA;
        cmd.sel_b  = sel_b_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    sel_b_next = 1'b0;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_fwd = 1'b1;
                state_next   = S_ERA_F;
            end
            S_ERA_F:
            begin
                if (sts.yr_ge400)
                begin
                    cmd.fwd_step = 1'b1;
                end
                else
                begin
                    cmd.chk_feb = 1'b1;
                    state_next  = S_CENT_F;
                end
            end
            S_CENT_F:
            begin
                cmd.kind = STEP_CENT;
                if (sts.yr_ge100)
                begin
                    cmd.fwd_step = 1'b1;
                end
                else
                begin
                    state_next = S_QUAD_F;
                end
            end
            S_QUAD_F:
            begin
                cmd.kind = STEP_QUAD;
                if (sts.yr_ge4)
                begin
                    cmd.fwd_step = 1'b1;
                end
                else
                begin
                    state_next = S_YEAR_F;
                end
            end
            S_YEAR_F:
            begin
                cmd.kind = STEP_YEAR;
                if (sts.yr_nz)
                begin
                    cmd.fwd_step = 1'b1;
                end
                else
                begin
                    state_next = S_SAVE;
                end
            end
            S_SAVE:
            begin
                cmd.save = 1'b1;
                if (sel_b_reg)
                begin
                    state_next = S_DONE;
                end
                else if (sts.op)
                begin
                    sel_b_next = 1'b1;
                    state_next = S_INIT;
                end
                else
                begin
                    state_next = S_INIT_R;
                end
            end
            S_INIT_R:
            begin
                cmd.init_rev = 1'b1;
                state_next   = S_ERA_R;
            end
            S_ERA_R:
            begin
                if (sts.n_ge_era)
                begin
                    cmd.rev_step = 1'b1;
                end
                else
                begin
                    state_next = S_CENT_R;
                end
            end
            S_CENT_R:
            begin
                cmd.kind = STEP_CENT;
                if (sts.n_ge_cent)
                begin
                    cmd.rev_step = 1'b1;
                end
                else
                begin
                    cmd.clr_cnt = 1'b1;
                    state_next  = S_QUAD_R;
                end
            end
            S_QUAD_R:
            begin
                cmd.kind = STEP_QUAD;
                if (sts.n_ge_quad)
                begin
                    cmd.rev_step = 1'b1;
                end
                else
                begin
                    state_next = S_YEAR_R;
                end
            end
            S_YEAR_R:
            begin
                cmd.kind = STEP_YEAR;
                if (sts.n_ge_year)
                begin
                    cmd.rev_step = 1'b1;
                end
                else
                begin
                    state_next = S_MONTH_R;
                end
            end
            S_MONTH_R:
            begin
                cmd.kind = STEP_MONTH;
                if (sts.n_ge_month)
                begin
                    cmd.rev_step = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result word valid flag
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_b_reg     <= sel_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a result word appears only from the done state
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside done state");

    // a free result register always takes the finished word
    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (!out_valid_reg || out_ready)) |=>
        ((state_reg == S_IDLE) && out_valid_reg))
        else $error("finished word not loaded");

    // only a shift runs the day number to date conversion
    a_rev_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT_R) |-> !sts.op)
        else $error("inverse conversion started for a compare");

endmodule

`default_nettype wire

/* sv/gregorian_date_arithmetic_core.sv */
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core
// Gregorian date shift by a signed day count, and day difference with
// compare flags between two dates.
// ----------------------------------------------------------------------------
// One request word is taken at a time; ready is high only while the block is
// idle, but a finished result word may still be waiting on the result port.
// Each date is turned into a day number by stepping its biased year down in
// 400-year, 100-year, 4-year and 1-year steps through one shared adder pair,
// and a shift turns the sum back into a date by the same steps plus up to
// eleven month steps. A converted date takes one step per 400 years of its
// biased year, about (Y + 400) / 400 of them for year Y, plus up to 30
// century, four-year and year steps. The way back takes one step per 146097
// days of the shifted day number N plus up to 41 century, four-year, year
// and month steps. Taking the word and loading the result are states of
// their own, and the load also waits while the previous result word is still
// held. An invalid year above MAX_YEAR runs the loops longer. The 400-year
// loops and the up to 24 four-year steps per conversion are the longest
// parts of the run. Invalid input dates give error 1, a shift that leaves
// years 0 to MAX_YEAR gives error 2; all other fields are then zero.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_arithmetic_core import gda_pkg::*; #(
    parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gda_in_if.sink     req,
    gda_out_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;
    logic out_valid;

    // sequencer
    gda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic and result registers
    gda_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .operation      (req.operation),
        .year_a         (req.year_a),
        .month_a        (req.month_a),
        .day_a          (req.day_a),
        .year_b         (req.year_b),
        .month_b        (req.month_b),
        .day_b          (req.day_b),
        .day_offset     (req.day_offset),
        .year_out       (rsp.year_out),
        .month_out      (rsp.month_out),
        .day_out        (rsp.day_out),
        .day_difference (rsp.day_difference),
        .a_before_b     (rsp.a_before_b),
        .dates_equal    (rsp.dates_equal),
        .error          (rsp.error)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

`default_nettype wire
